// ===== design/mwo_pkg.sv =====
// shared constants, types and the quarter-wave sine table for the oscillator
package mwo_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SAMPLE_WIDTH     = 16;

    localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_MUL_W = 30 + $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TRI_SHIFT  = 31 - SAMPLE_WIDTH;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CYCLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_START    = 3'd4;

    // waveform codes
    localparam logic [2:0] WAVE_SAW      = 3'd0;
    localparam logic [2:0] WAVE_SINE     = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_PWM      = 3'd4;

    localparam logic [16:0] DUTY_RESET = 17'd32768;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned FULL_POS_L  = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

    typedef logic [SAMPLE_WIDTH-2:0] t_sine_tab [SINE_TABLE_DEPTH];

    // sin(k/depth * pi/2) by a truncating Q30 taylor series, scaled to full scale
    function automatic logic [SAMPLE_WIDTH-2:0] sine_entry(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned e;
        longint          sum;
        x   = (k * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        t = ((t * x2) >> 30) / 6;   sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 20;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 42;  sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 72;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 110; sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 156; sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 210; sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 272; sum = sum + longint'(t);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        e = (longint'(sum) * FULL_POS_L + (64'd1 << 29)) >> 30;
        if (e > FULL_POS_L) begin
            e = FULL_POS_L;
        end
        return e[SAMPLE_WIDTH-2:0];
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            tab[k] = sine_entry(longint'(k));
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();
    // entry at a quarter cycle, reached only on odd quadrants with index zero
    localparam logic [SAMPLE_WIDTH-2:0] SINE_TOP = sine_entry(longint'(SINE_TABLE_DEPTH));

endpackage

// ===== design/multi_waveform_oscillator.sv =====
// Multi-waveform oscillator: a request with a sample index (taken when i_start is high and
// o_busy is low) returns one signed sample through a registered pipeline, marked by a one-cycle
// o_valid. o_busy never rises, so a new request may be issued in every cycle and results
// come out in request order at one per cycle; the receiver cannot stall and must take each
// word in its cycle. The stages are input capture, the two 32-bit phase multiplies,
// the phase offset add with the pwm duty compare, and waveform shaping with the sine table
// lookup. Write the configuration registers only while no request is in flight.
module multi_waveform_oscillator
    import mwo_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [30:0]                    i_sample_index,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    localparam logic [SAMPLE_WIDTH-1:0] FULL_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] NEG_HALF = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // configuration
    logic [2:0]  r_wave_sel;
    logic [31:0] r_phase_step;
    logic [31:0] r_phase_offset;
    logic [16:0] r_duty;
    logic [30:0] r_pwm_start;

    // pipeline
    logic        r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic [30:0] r_a_idx, r_a_diff;
    logic        r_a_before;
    logic [31:0] r_b_prod, r_b_pp;
    logic        r_b_before;
    logic [31:0] r_c_phase;
    logic        r_c_pwm_high;
    logic [SAMPLE_WIDTH-1:0] r_d_sample;

    logic        accept;
    logic [62:0] n_b_prod, n_b_pp;
    logic [31:0] n_c_phase;
    logic        n_c_pwm_high;
    logic [SAMPLE_WIDTH-1:0] n_d_sample;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel     <= WAVE_SAW;
            r_phase_step   <= '0;
            r_phase_offset <= '0;
            r_duty         <= DUTY_RESET;
            r_pwm_start    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WAVE_SEL:     r_wave_sel     <= i_cfg_data[2:0];
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                REG_PHASE_OFFSET: r_phase_offset <= i_cfg_data;
                REG_DUTY_CYCLE:   r_duty         <= i_cfg_data[16:0];
                REG_PWM_START:    r_pwm_start    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // stage a: capture, pwm index relative to its start
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_idx    <= i_sample_index;
            r_a_diff   <= i_sample_index - r_pwm_start;
            r_a_before <= i_sample_index < r_pwm_start;
        end
    end

    // stage b: phase multiplies, only the low 32 bits matter
    assign n_b_prod = 63'(r_a_idx) * 63'(r_phase_step);
    assign n_b_pp   = 63'(r_a_diff) * 63'(r_phase_step);

    always_ff @(posedge i_clk) begin
        r_b_prod   <= n_b_prod[31:0];
        r_b_pp     <= n_b_pp[31:0];
        r_b_before <= r_a_before;
    end

    // stage c: phase offset and duty compare
    assign n_c_phase    = r_b_prod + r_phase_offset;
    assign n_c_pwm_high = r_b_before || ({1'b0, r_b_pp} < {r_duty, 16'h0000});

    always_ff @(posedge i_clk) begin
        r_c_phase    <= n_c_phase;
        r_c_pwm_high <= n_c_pwm_high;
    end

    // stage d: waveform shaping
    logic [31:0]             tri_rise, tri_mid, tri_fall;
    logic [31:0]             tri_mid_sh;
    logic [SAMPLE_WIDTH-1:0] tri_val;
    logic [SINE_MUL_W-1:0]   sine_prod;
    logic [SINE_IDX_W-1:0]   sine_idx, sine_ridx;
    logic [SAMPLE_WIDTH-2:0] sine_mag;
    logic [SAMPLE_WIDTH-1:0] sine_val;

    always_comb begin
        tri_rise   = r_c_phase >> TRI_SHIFT;
        tri_mid    = r_c_phase - 32'h4000_0000;
        tri_mid_sh = tri_mid >> TRI_SHIFT;
        tri_fall   = (r_c_phase - 32'hC000_0000) >> TRI_SHIFT;
        if (!r_c_phase[31] && !r_c_phase[30]) begin
            tri_val = {1'b0, tri_rise[SAMPLE_WIDTH-2:0]};
        end else if (r_c_phase < 32'hC000_0000) begin
            // peak of one saturates to full scale
            if (tri_mid_sh[SAMPLE_WIDTH-1:0] == '0) begin
                tri_val = FULL_POS;
            end else begin
                tri_val = NEG_HALF - tri_mid_sh[SAMPLE_WIDTH-1:0];
            end
        end else begin
            tri_val = {1'b1, tri_fall[SAMPLE_WIDTH-2:0]};
        end
    end

    always_comb begin
        sine_prod = SINE_MUL_W'(r_c_phase[29:0]) * SINE_MUL_W'(SINE_TABLE_DEPTH);
        sine_idx  = sine_prod[30 +: SINE_IDX_W];
        sine_ridx = SINE_IDX_W'(SINE_TABLE_DEPTH) - sine_idx;
        if (r_c_phase[30]) begin
            sine_mag = (sine_idx == '0) ? SINE_TOP : SINE_TAB[sine_ridx];
        end else begin
            sine_mag = SINE_TAB[sine_idx];
        end
        if (r_c_phase[31]) begin
            sine_val = '0 - {1'b0, sine_mag};
        end else begin
            sine_val = {1'b0, sine_mag};
        end
    end

    always_comb begin
        case (r_wave_sel)
            WAVE_SAW:      n_d_sample = r_c_phase[31 -: SAMPLE_WIDTH];
            WAVE_SINE:     n_d_sample = sine_val;
            WAVE_SQUARE:   n_d_sample = r_c_phase[31] ? FULL_POS : NEG_HALF;
            WAVE_TRIANGLE: n_d_sample = tri_val;
            WAVE_PWM:      n_d_sample = r_c_pwm_high ? FULL_POS : '0;
            default:       n_d_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_d_sample <= n_d_sample;
    end

    assign o_valid  = r_d_valid;
    assign o_sample = r_d_sample;

    // pipeline never drops a word
    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |=> o_valid)
        else $error("stage c word did not reach the output");

    a_square_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(r_wave_sel) == WAVE_SQUARE |->
            o_sample == FULL_POS || o_sample == NEG_HALF)
        else $error("square output off its two levels");

    a_pwm_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(r_wave_sel) == WAVE_PWM |->
            o_sample == FULL_POS || o_sample == '0)
        else $error("pwm output off its two levels");

    // sine is symmetric, so the most negative code never appears
    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(r_wave_sel) == WAVE_SINE |-> o_sample != NEG_HALF)
        else $error("sine output reached negative half code");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the multi-waveform oscillator
`timescale 1ns / 100ps

module testbench;
    import mwo_pkg::*;

    localparam int          CLK_HALF     = 2;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          PIPE_CYCLES  = 6;
    localparam int          RAND_PHASES  = 12;
    localparam int          PHASE_ITEMS  = 38;
    localparam int          SINE_DEPTH   = 256;
    localparam int          FS_CODE      = 32767;
    localparam int          NEG_CODE     = 32768;
    localparam longint unsigned QTR_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30     = 64'd1073741824;

    // selector codes with no waveform behind them
    localparam logic [2:0] WAVE_SPARE0 = 3'd5;
    localparam logic [2:0] WAVE_SPARE1 = 3'd6;
    localparam logic [2:0] WAVE_SPARE2 = 3'd7;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    logic [30:0]                    i_sample_index;
    logic                           o_valid;
    logic signed [SAMPLE_WIDTH-1:0] o_sample;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [CFG_IDX_W-1:0]           i_cfg_index;
    logic [CFG_DATA_W-1:0]          i_cfg_data;

    multi_waveform_oscillator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_sample_index (i_sample_index),
        .o_valid        (o_valid),
        .o_sample       (o_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    class sample_tracker;
        logic [2:0]  wave_sel;
        logic [31:0] phase_step;
        logic [31:0] phase_offset;
        logic [16:0] duty;
        logic [30:0] pwm_start;
        int          quarter_sine [SINE_DEPTH+1];
        logic signed [15:0] expected_samples [$];
        int          errors;

        function new();
            wave_sel     = WAVE_SAW;
            phase_step   = '0;
            phase_offset = '0;
            duty         = 17'd32768;
            pwm_start    = '0;
            errors       = 0;
            for (int k = 0; k <= SINE_DEPTH; k++) begin
                quarter_sine[k] = sine_code(k);
            end
        endfunction

        // truncating Q30 taylor series up to x^17, rounded to full scale
        function int sine_code(int k);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned e;
            longint          acc;
            int              n;
            x   = k;
            x   = (x * QTR_TURN_Q30) / SINE_DEPTH;
            x2  = (x * x) >> 30;
            t   = x;
            acc = longint'(x);
            for (n = 1; n <= 8; n++) begin
                t = (t * x2) >> 30;
                t = t / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(t);
                end else begin
                    acc = acc + longint'(t);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > longint'(UNIT_Q30)) begin
                acc = longint'(UNIT_Q30);
            end
            e = acc;
            e = (e * FS_CODE + 64'd536870912) >> 30;
            if (e > FS_CODE) begin
                e = FS_CODE;
            end
            return int'(e);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_WAVE_SEL:     wave_sel     = data[2:0];
                REG_PHASE_STEP:   phase_step   = data;
                REG_PHASE_OFFSET: phase_offset = data;
                REG_DUTY_CYCLE:   duty         = data[16:0];
                REG_PWM_START:    pwm_start    = data[30:0];
                default: ;
            endcase
        endfunction

        function logic signed [15:0] predict_sample(logic [30:0] idx);
            logic [31:0]     phase;
            logic [31:0]     pwm_phase;
            longint unsigned pwm_phase_l;
            longint unsigned duty_lim;
            int              v;
            int              ti;
            phase = {1'b0, idx} * phase_step + phase_offset;
            case (wave_sel)
                WAVE_SAW: v = $signed(phase[31:16]);
                WAVE_SINE: begin
                    ti = phase[29:22];
                    v  = phase[30] ? quarter_sine[SINE_DEPTH - ti] : quarter_sine[ti];
                    if (phase[31]) begin
                        v = -v;
                    end
                end
                WAVE_SQUARE: v = phase[31] ? FS_CODE : -NEG_CODE;
                WAVE_TRIANGLE: begin
                    if (phase < 32'h4000_0000) begin
                        v = int'(phase >> 15);
                    end else if (phase < 32'hC000_0000) begin
                        v = NEG_CODE - int'((phase - 32'h4000_0000) >> 15);
                        if (v > FS_CODE) begin
                            v = FS_CODE;
                        end
                    end else begin
                        v = -NEG_CODE + int'((phase - 32'hC000_0000) >> 15);
                    end
                end
                WAVE_PWM: begin
                    if (idx < pwm_start) begin
                        v = FS_CODE;
                    end else begin
                        pwm_phase   = ({1'b0, idx} - {1'b0, pwm_start}) * phase_step;
                        pwm_phase_l = pwm_phase;
                        duty_lim    = duty;
                        duty_lim    = duty_lim << 16;
                        v = (pwm_phase_l < duty_lim) ? FS_CODE : 0;
                    end
                end
                default: v = 0;
            endcase
            return v[15:0];
        endfunction

        function void note_request(logic [30:0] idx);
            expected_samples.push_back(predict_sample(idx));
        endfunction

        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: sample with nothing pending, expected none, actual %0d",
                         $time, got);
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: sample mismatch, expected %0d, actual %0d",
                         $time, want, got);
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    sample_tracker tracker = new();
    int            stall_cycles = 0;
    logic [30:0]   cur_start = '0;
    logic [2:0]    wave_codes [8] = '{WAVE_SAW, WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE,
                                      WAVE_PWM, WAVE_SPARE0, WAVE_SPARE1, WAVE_SPARE2};
    int            idle_pct [3] = '{0, 78, 24};

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.write_reg(i_cfg_index, i_cfg_data);
            end
            if (o_valid) begin
                tracker.check_sample(o_sample);
            end
            if (i_start && !o_busy) begin
                tracker.note_request(i_sample_index);
            end
            if ((i_cfg_valid && o_cfg_ready) || o_valid || (i_start && !o_busy)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    task automatic request_sample(input logic [30:0] idx, input int idle);
        while ($urandom_range(0, 99) < idle) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_sample_index <= idx;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
    endtask

    // stop issuing and let every pending word come back
    task automatic drain();
        i_start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (tracker.pending() != 0);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_regs(input logic [31:0] wave, input logic [31:0] step,
                            input logic [31:0] offset, input logic [31:0] duty,
                            input logic [31:0] start);
        drain();
        cfg_write(REG_WAVE_SEL, wave);
        cfg_write(REG_PHASE_STEP, step);
        cfg_write(REG_PHASE_OFFSET, offset);
        cfg_write(REG_DUTY_CYCLE, duty);
        cfg_write(REG_PWM_START, start);
        i_cfg_valid <= 1'b0;
        cur_start = start[30:0];
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 1 << 20);
            3:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_duty();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd65536;
            2:       return $urandom & 32'h0001_FFFF;
            3:       return $urandom;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic logic [30:0] pick_index();
        logic [31:0] near;
        near = {1'b0, cur_start} + $urandom_range(0, 40) - 32'd20;
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2, 3:    return 31'($urandom_range(0, 4095));
            4, 5:    return near[30:0];
            default: return 31'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] hi;
        int          r;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_sample_index = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: saw with zero phase step
        request_sample(31'd0, 0);
        request_sample(31'h7FFF_FFFF, 0);

        set_regs({29'd0, WAVE_SAW}, 32'h0100_0000, 32'h0, 32'd32768, 32'd0);
        request_sample(31'd0, 0);
        request_sample(31'd127, 0);
        request_sample(31'd128, 0);
        request_sample(31'd255, 0);
        request_sample(31'h7FFF_FFFF, 0);

        // one table step per index, quadrant edges included
        set_regs({29'd0, WAVE_SINE}, 32'h0040_0000, 32'h0, 32'd32768, 32'd0);
        request_sample(31'd0, 0);
        request_sample(31'd255, 0);
        request_sample(31'd256, 0);
        request_sample(31'd512, 0);
        request_sample(31'd768, 0);

        set_regs({29'd0, WAVE_SQUARE}, 32'h8000_0000, 32'h7FFF_FFFF, 32'd32768, 32'd0);
        request_sample(31'd0, 0);
        request_sample(31'd1, 0);

        set_regs({29'd0, WAVE_TRIANGLE}, 32'h4000_0000, 32'h0, 32'd32768, 32'd0);
        request_sample(31'd0, 0);
        request_sample(31'd1, 0);
        request_sample(31'd2, 0);
        request_sample(31'd3, 0);

        // before pwm start, then zero duty at the start index
        set_regs({29'd0, WAVE_PWM}, 32'h0100_0000, 32'h0, 32'd0, 32'd100);
        request_sample(31'd99, 0);
        request_sample(31'd100, 0);

        // duty above full, wide register data
        set_regs({29'h1FFF_FFFF, WAVE_PWM}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_0000);
        request_sample(31'h7FFF_FFFF, 0);

        set_regs({29'd0, WAVE_PWM}, 32'h0, 32'h0, 32'd65536, 32'd0);
        request_sample(31'd5, 0);

        set_regs({29'h1FFF_FFFF, WAVE_SPARE0}, 32'h1234_5678, 32'h0, 32'd32768, 32'd0);
        request_sample(31'd12345, 0);
        set_regs({29'd0, WAVE_SPARE1}, 32'h1234_5678, 32'h0, 32'd32768, 32'd0);
        request_sample(31'd12345, 0);
        set_regs({29'd0, WAVE_SPARE2}, 32'h1234_5678, 32'h0, 32'd32768, 32'd0);
        request_sample(31'd12345, 0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            r  = $urandom_range(0, 19);
            hi = $urandom;
            if ($urandom_range(0, 3) != 0) begin
                hi = '0;
            end
            set_regs({hi[31:3], wave_codes[(r < 17) ? (r % 5) : (r - 12)]}, pick_word(),
                     pick_word(), pick_duty(), pick_start());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                request_sample(pick_index(), idle_pct[ph % 3]);
            end
        end

        drain();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
